[sv/http_chunked_body_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Chunked body decoder assertion macros
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that prop holds at every clock edge outside reset.
`define CHBD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that expr never holds outside reset.
`define CHBD_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define CHBD_ASSERT(lbl, clk, rst, prop, msg)
`define CHBD_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

[sv/chbd_pkg.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared types and byte codes for the front, back and top modules.
// ----------------------------------------------------------------------------
package chbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE_FIRST,
    PH_SIZE_MORE,
    PH_SIZE_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_FINAL_CR,
    PH_FINAL_LF
  } phase_t;

  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;
  localparam logic [31:0] LENGTH_MAX  = 32'hFFFF_FFFF;

  // Classified input byte, as handed from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } byte_class_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [31:0] body_length;
  } result_t;

endpackage

[sv/chbd_front.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder front end
// Classify each raw byte: hex digit value, CR, LF.
// ----------------------------------------------------------------------------
module chbd_front (
  input  logic [7:0]          in_byte,
  output chbd_pkg::byte_class_t cls
);

  always_comb begin
    cls.data    = in_byte;
    cls.is_cr   = (in_byte == chbd_pkg::BYTE_CR);
    cls.is_lf   = (in_byte == chbd_pkg::BYTE_LF);
    cls.hex_ok  = 1'b0;
    cls.hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_byte - 8'h37);
    end
  end

endmodule

[sv/chbd_fifo.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder queue
// Two-entry queue; push and pop in the same cycle sustain one per cycle, but a push is refused while full.
// ----------------------------------------------------------------------------
module chbd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wp <= !wp;
      if (do_rd) rp <= !rp;
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot[wp] <= wr_data;
  end

endmodule

[sv/chbd_back.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder back end
// Run the chunk framing state machine on classified bytes.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_assert.svh"

module chbd_back #(
  parameter int SIZE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [31:0]           cfg_wdata,
  input  logic                  in_valid,
  input  chbd_pkg::byte_class_t in_cls,
  output logic                  in_take,
  input  logic                  out_full,
  output logic                  out_push,
  output chbd_pkg::result_t     out_item
);

  localparam int LW = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 4;
  localparam logic [LW-1:0] RANGE = {{(LW-SIZE_BITS){1'b0}}, {SIZE_BITS{1'b1}}};

  chbd_pkg::phase_t      phase;
  chbd_pkg::phase_t      phase_next;
  logic [31:0]           size_limit;
  logic [SIZE_BITS-1:0]  size_acc;
  logic [SIZE_BITS-1:0]  size_acc_next;
  logic [SIZE_BITS-1:0]  remaining;
  logic [SIZE_BITS-1:0]  remaining_next;
  logic [31:0]           total_length;
  logic [31:0]           total_length_next;
  logic [LW-1:0]         acc_shifted;
  logic [LW-1:0]         lim_w;
  logic [LW-1:0]         eff_limit;
  logic                  over;
  logic                  bad;

  assign in_take     = in_valid && !out_full;
  assign acc_shifted = LW'({size_acc, in_cls.hex_val});
  assign lim_w       = LW'(size_limit);
  assign eff_limit   = (lim_w < RANGE) ? lim_w : RANGE;
  assign over        = (acc_shifted > eff_limit);

  // Flag a byte that does not fit the current phase
  always_comb begin
    unique case (phase)
      chbd_pkg::PH_SIZE_FIRST: bad = !in_cls.hex_ok || over;
      chbd_pkg::PH_SIZE_MORE:  bad = in_cls.hex_ok ? over : !in_cls.is_cr;
      chbd_pkg::PH_SIZE_LF:    bad = !in_cls.is_lf;
      chbd_pkg::PH_DATA:       bad = 1'b0;
      chbd_pkg::PH_DATA_CR:    bad = !in_cls.is_cr;
      chbd_pkg::PH_DATA_LF:    bad = !in_cls.is_lf;
      chbd_pkg::PH_FINAL_CR:   bad = !in_cls.is_cr;
      chbd_pkg::PH_FINAL_LF:   bad = !in_cls.is_lf;
      default:                 bad = 1'b1;
    endcase
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (bad) begin
      phase_next = chbd_pkg::PH_SIZE_FIRST;
    end else begin
      unique case (phase)
        chbd_pkg::PH_SIZE_FIRST,
        chbd_pkg::PH_SIZE_MORE: begin
          phase_next = in_cls.hex_ok ? chbd_pkg::PH_SIZE_MORE : chbd_pkg::PH_SIZE_LF;
        end
        chbd_pkg::PH_SIZE_LF: begin
          phase_next = (size_acc == '0) ? chbd_pkg::PH_FINAL_CR : chbd_pkg::PH_DATA;
        end
        chbd_pkg::PH_DATA: begin
          if (remaining <= SIZE_BITS'(1)) phase_next = chbd_pkg::PH_DATA_CR;
        end
        chbd_pkg::PH_DATA_CR:  phase_next = chbd_pkg::PH_DATA_LF;
        chbd_pkg::PH_DATA_LF:  phase_next = chbd_pkg::PH_SIZE_FIRST;
        chbd_pkg::PH_FINAL_CR: phase_next = chbd_pkg::PH_FINAL_LF;
        chbd_pkg::PH_FINAL_LF: phase_next = chbd_pkg::PH_SIZE_FIRST;
        default:               phase_next = chbd_pkg::PH_SIZE_FIRST;
      endcase
    end
  end

  // Datapath updates and result
  always_comb begin
    size_acc_next        = size_acc;
    remaining_next       = remaining;
    total_length_next    = total_length;
    out_push             = 1'b0;
    out_item.data_byte   = 8'd0;
    out_item.status      = chbd_pkg::ST_PAYLOAD;
    out_item.body_length = 32'd0;
    if (bad) begin
      size_acc_next   = '0;
      remaining_next  = '0;
      out_push        = in_take;
      out_item.status = chbd_pkg::ST_ERROR;
    end else begin
      unique case (phase)
        chbd_pkg::PH_SIZE_FIRST,
        chbd_pkg::PH_SIZE_MORE: begin
          if (in_cls.hex_ok) size_acc_next = acc_shifted[SIZE_BITS-1:0];
        end
        chbd_pkg::PH_SIZE_LF: begin
          if (size_acc != '0) remaining_next = size_acc;
          size_acc_next = '0;
        end
        chbd_pkg::PH_DATA: begin
          if (total_length != chbd_pkg::LENGTH_MAX) total_length_next = total_length + 32'd1;
          if (remaining != '0) remaining_next = remaining - SIZE_BITS'(1);
          out_push           = in_take;
          out_item.data_byte = in_cls.data;
        end
        chbd_pkg::PH_FINAL_LF: begin
          total_length_next    = 32'd0;
          out_push             = in_take;
          out_item.status      = chbd_pkg::ST_DONE;
          out_item.body_length = total_length;
        end
        default: begin
          size_acc_next = size_acc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= chbd_pkg::PH_SIZE_FIRST;
      size_limit   <= chbd_pkg::LIMIT_RESET;
      size_acc     <= '0;
      remaining    <= '0;
      total_length <= 32'd0;
    end else begin
      if (cfg_wen) size_limit <= cfg_wdata;
      if (in_take) begin
        phase        <= phase_next;
        size_acc     <= size_acc_next;
        remaining    <= remaining_next;
        total_length <= total_length_next;
      end
    end
  end

  `CHBD_NEVER(a_status_code, clk, rst, out_push && out_item.status != chbd_pkg::ST_PAYLOAD && out_item.status != chbd_pkg::ST_DONE && out_item.status != chbd_pkg::ST_ERROR, "undefined status pushed")
  `CHBD_ASSERT(a_data_emits, clk, rst, (in_take && phase == chbd_pkg::PH_DATA) |-> (out_push && out_item.status == chbd_pkg::ST_PAYLOAD), "payload byte not passed out")
  `CHBD_ASSERT(a_done_clears, clk, rst, (out_push && out_item.status == chbd_pkg::ST_DONE) |=> (total_length == 32'd0 && phase == chbd_pkg::PH_SIZE_FIRST), "body end did not clear length")
  `CHBD_NEVER(a_push_needs_take, clk, rst, out_push && !in_take, "result pushed without a consumed byte")

endmodule

[sv/http_chunked_body_decoder.sv]
// Throughput: one byte per cycle, sustained while the result queue is not full; the front
// queue and the result queue each take one transaction per cycle while the framing state
// machine steps once per byte.
// Reset (rst, synchronous, active high): empties both queues, returns the framer to
// the first size digit, clears the running length and sets size_limit to 0xFFFFFFFF.
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Front end classifies bytes into a short queue; the back end runs the chunk
// framing and pushes payload, body-complete and error results into an output
// queue read through empty/pop.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Byte input, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  // Result output, queue style
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  data_byte,
  output logic [1:0]  status,
  output logic [31:0] body_length,
  // size_limit register write
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata
);

  localparam int CLS_W = $bits(chbd_pkg::byte_class_t);
  localparam int RES_W = $bits(chbd_pkg::result_t);

  chbd_pkg::byte_class_t cls_in;
  chbd_pkg::byte_class_t cls_head;
  logic                  mid_empty;
  logic                  mid_take;
  logic                  res_full;
  logic                  res_push;
  chbd_pkg::result_t     res_in;
  chbd_pkg::result_t     res_head;

  // Classify the raw byte on the way in
  chbd_front u_front (
    .in_byte (in_byte),
    .cls     (cls_in)
  );

  // Hold classified bytes between front and back; full here stalls the sender
  chbd_fifo #(
    .WIDTH (CLS_W)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cls_in),
    .full    (full),
    .rd_en   (mid_take),
    .rd_data (cls_head),
    .empty   (mid_empty)
  );

  // Advance the framing state machine one byte per transaction
  chbd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (!mid_empty),
    .in_cls    (cls_head),
    .in_take   (mid_take),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_item  (res_in)
  );

  // Hold results until the consumer pops them
  chbd_fifo #(
    .WIDTH (RES_W)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign data_byte   = res_head.data_byte;
  assign status      = res_head.status;
  assign body_length = res_head.body_length;

endmodule
